// ===== hw/rtl/tlvp_pkg.sv =====
// Shared types and constants for the telemetry TLV group packer.
// No dependencies; used by the front, queue and back modules.
`timescale 1ns / 1ps
`default_nettype none

package tlvp_pkg;

	localparam int PKT_BYTES = 12;

	localparam logic [7:0] TYPE_TEMP = 8'h01;
	localparam logic [7:0] TYPE_HUM  = 8'h02;
	localparam logic [7:0] TYPE_LUX  = 8'h03;
	localparam logic [7:0] TYPE_ACC  = 8'h10;
	localparam logic [7:0] TYPE_GYR  = 8'h11;
	localparam logic [7:0] TYPE_VIB  = 8'h12;

	localparam logic [7:0] LEN_SHORT = 8'd2;
	localparam logic [7:0] LEN_TRIPLE = 8'd6;

	localparam logic [15:0] VIB_MAX = 16'hFFFF;

	localparam logic [1:0] GRP_ENV  = 2'd0;
	localparam logic [1:0] GRP_ACC  = 2'd1;
	localparam logic [1:0] GRP_GYR  = 2'd2;

	// One finished packet: byte 0 goes out first.
	typedef struct packed {
		logic [3:0]                  len;
		logic [PKT_BYTES-1:0][7:0]   data;
	} packet_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlvp_front.sv =====
// Front end: takes snapshots, tracks motion history and group rotation,
// and builds the TLV packet for each snapshot. Depends on tlvp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlvp_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [7:0]          limit,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                env_valid,
	input  wire logic                lux_valid,
	input  wire logic                motion_valid,
	input  wire logic signed [15:0]  temperature,
	input  wire logic [15:0]         humidity,
	input  wire logic [15:0]         light_level,
	input  wire logic signed [15:0]  accel_x,
	input  wire logic signed [15:0]  accel_y,
	input  wire logic signed [15:0]  accel_z,
	input  wire logic signed [15:0]  gyro_x,
	input  wire logic signed [15:0]  gyro_y,
	input  wire logic signed [15:0]  gyro_z,
	input  wire logic                q_full,
	output logic                     push,
	output tlvp_pkg::packet_t        push_pkt
);

	logic [1:0]  grp_q;
	logic        prior_valid_q;
	logic [15:0] prior_x_q, prior_y_q, prior_z_q;

	logic        valid_s1;
	logic [1:0]  grp_s1;
	logic        env_s1, lux_s1, mot_s1, vib_ok_s1;
	logic [15:0] vib_s1;
	logic [15:0] temp_s1, hum_s1, lux_val_s1;
	logic [15:0] ax_s1, ay_s1, az_s1, gx_s1, gy_s1, gz_s1;

	logic        accept;
	logic [1:0]  gstart;
	logic [15:0] ad_x, ad_y, ad_z;
	logic [17:0] ad_sum;
	logic [15:0] vib_now;
	tlvp_pkg::packet_t p_env, p_acc, p_gyr, chosen;

	function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] d;
		d = {a[15], a} - {b[15], b};
		return d[16] ? 16'(-d) : d[15:0];
	endfunction

	function automatic logic [31:0] rec_short(input logic [7:0] typ, input logic [15:0] v);
		return {v, tlvp_pkg::LEN_SHORT, typ};
	endfunction

	// temperature, humidity, light: up to three 4-byte records
	function automatic tlvp_pkg::packet_t pack_env(input logic env, input logic lux,
			input logic [15:0] t, input logic [15:0] h, input logic [15:0] l,
			input logic [7:0] cap);
		tlvp_pkg::packet_t p;
		logic [2:0][31:0] w;
		logic [1:0] n;
		logic t_ok, h_ok, l_ok;
		w = '0;
		n = 2'd0;
		t_ok = env && (cap >= 8'd4);
		h_ok = env && (cap >= (t_ok ? 8'd8 : 8'd4));
		l_ok = lux && (cap >= 8'd4 + {4'd0, 2'(t_ok) + 2'(h_ok), 2'd0});
		if (t_ok) begin
			w[n] = rec_short(tlvp_pkg::TYPE_TEMP, t);
			n = n + 2'd1;
		end
		if (h_ok) begin
			w[n] = rec_short(tlvp_pkg::TYPE_HUM, h);
			n = n + 2'd1;
		end
		if (l_ok) begin
			w[n] = rec_short(tlvp_pkg::TYPE_LUX, l);
			n = n + 2'd1;
		end
		p.data = w;
		p.len = {n, 2'd0};
		return p;
	endfunction

	// one triple record, then the vibration record
	function automatic tlvp_pkg::packet_t pack_motion(input logic [7:0] typ,
			input logic mot, input logic vok, input logic [15:0] x,
			input logic [15:0] y, input logic [15:0] z, input logic [15:0] vib,
			input logic [7:0] cap);
		tlvp_pkg::packet_t p;
		logic [95:0] vec;
		logic a_ok, v_ok;
		vec = '0;
		a_ok = mot && (cap >= 8'd8);
		v_ok = vok && (cap >= (a_ok ? 8'd12 : 8'd4));
		if (a_ok)
			vec[63:0] = {z, y, x, tlvp_pkg::LEN_TRIPLE, typ};
		if (v_ok) begin
			if (a_ok)
				vec[95:64] = rec_short(tlvp_pkg::TYPE_VIB, vib);
			else
				vec[31:0] = rec_short(tlvp_pkg::TYPE_VIB, vib);
		end
		p.data = vec;
		p.len = (a_ok ? 4'd8 : 4'd0) + (v_ok ? 4'd4 : 4'd0);
		return p;
	endfunction

	assign ad_x = abs_diff(accel_x, prior_x_q);
	assign ad_y = abs_diff(accel_y, prior_y_q);
	assign ad_z = abs_diff(accel_z, prior_z_q);
	assign ad_sum = {2'd0, ad_x} + {2'd0, ad_y} + {2'd0, ad_z};
	assign vib_now = (ad_sum[17:16] != 2'd0) ? tlvp_pkg::VIB_MAX : ad_sum[15:0];

	// code 3 never occurs but is treated as the environment group
	assign gstart = (grp_q == 2'd3) ? tlvp_pkg::GRP_ENV : grp_q;

	assign p_env = pack_env(env_s1, lux_s1, temp_s1, hum_s1, lux_val_s1, limit);
	assign p_acc = pack_motion(tlvp_pkg::TYPE_ACC, mot_s1, vib_ok_s1, ax_s1, ay_s1, az_s1,
		vib_s1, limit);
	assign p_gyr = pack_motion(tlvp_pkg::TYPE_GYR, mot_s1, vib_ok_s1, gx_s1, gy_s1, gz_s1,
		vib_s1, limit);

	// first group in rotation order that writes something
	always_comb begin
		unique case (grp_s1)
			tlvp_pkg::GRP_ACC:
				chosen = (p_acc.len != 4'd0) ? p_acc : ((p_gyr.len != 4'd0) ? p_gyr : p_env);
			tlvp_pkg::GRP_GYR:
				chosen = (p_gyr.len != 4'd0) ? p_gyr : ((p_env.len != 4'd0) ? p_env : p_acc);
			default:
				chosen = (p_env.len != 4'd0) ? p_env : ((p_acc.len != 4'd0) ? p_acc : p_gyr);
		endcase
	end

	assign push = valid_s1 && (chosen.len != 4'd0) && !q_full;
	assign push_pkt = chosen;
	assign in_stall = valid_s1 && (chosen.len != 4'd0) && q_full;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			grp_q <= tlvp_pkg::GRP_ENV;
			prior_valid_q <= 1'b0;
			prior_x_q <= '0;
			prior_y_q <= '0;
			prior_z_q <= '0;
		end else begin
			if (accept && (limit != 8'd0)) begin
				valid_s1 <= 1'b1;
				grp_q <= (gstart == tlvp_pkg::GRP_GYR) ? tlvp_pkg::GRP_ENV : gstart + 2'd1;
				if (motion_valid) begin
					prior_valid_q <= 1'b1;
					prior_x_q <= accel_x;
					prior_y_q <= accel_y;
					prior_z_q <= accel_z;
				end
			end else if (!in_stall) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// snapshot payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			grp_s1 <= gstart;
			env_s1 <= env_valid;
			lux_s1 <= lux_valid;
			mot_s1 <= motion_valid;
			vib_ok_s1 <= motion_valid && prior_valid_q;
			vib_s1 <= vib_now;
			temp_s1 <= temperature;
			hum_s1 <= humidity;
			lux_val_s1 <= light_level;
			ax_s1 <= accel_x;
			ay_s1 <= accel_y;
			az_s1 <= accel_z;
			gx_s1 <= gyro_x;
			gy_s1 <= gyro_y;
			gz_s1 <= gyro_z;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tlvp_queue.sv =====
// Small packet queue between the front end and the byte serializer.
// Depends on tlvp_pkg for the packet type.
`timescale 1ns / 1ps
`default_nettype none

module tlvp_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire tlvp_pkg::packet_t  push_pkt,
	output logic                    full,
	input  wire logic               pop,
	output logic                    head_valid,
	output tlvp_pkg::packet_t       head_pkt
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	tlvp_pkg::packet_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_pkt = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_pkt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tlvp_back.sv =====
// Back end: walks the packet at the queue head one byte per word into
// the output register and flags the final byte. Depends on tlvp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlvp_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               head_valid,
	input  wire tlvp_pkg::packet_t  head_pkt,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [7:0]              payload_byte,
	output logic                    last_byte
);

	logic [3:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       load;
	logic       at_end;

	assign load = head_valid && (!valid_q || !out_stall);
	assign at_end = (idx_q == head_pkt.len - 4'd1);
	assign pop = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q <= at_end ? 4'd0 : idx_q + 4'd1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head_pkt.data[idx_q];
			last_q <= at_end;
		end
	end

	assign out_valid = valid_q;
	assign payload_byte = byte_q;
	assign last_byte = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/telemetry_tlv_group_packer.sv =====
// Telemetry TLV group packer, top level.
// Input channel: one sensor snapshot per word (in_valid / in_stall).
// Output channel: the TLV packet for that snapshot, one byte per word
// (out_valid / out_stall), last_byte high on the packet's final byte.
// Config channel: cfg_valid / cfg_ready / cfg_data writes buffer_limit
// (reset 31); cfg_ready is always high. Write it only while idle.
// The snapshot is registered in the front end, pushed into the packet queue, and
// loaded byte by byte into the output register. A snapshot with nothing to send, or any
// snapshot while buffer_limit is zero, produces no bytes.
// Throughput: one byte per cycle through the output register while out_stall is low;
// a snapshot's packet has 4 to 12 bytes.
// The front end takes the next snapshot while earlier packets drain, and
// holds in_stall only when the packet queue is full.
// Reset clears the group rotation, motion history, queue and output valid.
// While out_stall is high the current byte holds and the queue fills up.
`timescale 1ns / 1ps
`default_nettype none

module telemetry_tlv_group_packer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [7:0]         cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               env_valid,
	input  wire logic               lux_valid,
	input  wire logic               motion_valid,
	input  wire logic signed [15:0] temperature,
	input  wire logic [15:0]        humidity,
	input  wire logic [15:0]        light_level,
	input  wire logic signed [15:0] accel_x,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_z,
	input  wire logic signed [15:0] gyro_x,
	input  wire logic signed [15:0] gyro_y,
	input  wire logic signed [15:0] gyro_z,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [7:0]              payload_byte,
	output logic                    last_byte
);

	logic [7:0] limit_q;
	logic       q_full, push, pop, head_valid;
	tlvp_pkg::packet_t push_pkt, head_pkt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= 8'd31;
		else if (cfg_valid && cfg_ready)
			limit_q <= cfg_data;
	end

	tlvp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.limit        (limit_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.env_valid    (env_valid),
		.lux_valid    (lux_valid),
		.motion_valid (motion_valid),
		.temperature  (temperature),
		.humidity     (humidity),
		.light_level  (light_level),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.accel_z      (accel_z),
		.gyro_x       (gyro_x),
		.gyro_y       (gyro_y),
		.gyro_z       (gyro_z),
		.q_full       (q_full),
		.push         (push),
		.push_pkt     (push_pkt)
	);

	tlvp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_pkt   (push_pkt),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_pkt   (head_pkt)
	);

	tlvp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_pkt     (head_pkt),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_byte (payload_byte),
		.last_byte    (last_byte)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/tlvp_checker.sv =====
// Port-level checks for the telemetry TLV group packer, bound to the top.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module tlvp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  payload_byte,
	input wire logic        last_byte
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_byte) && $stable(last_byte))
		else $error("output word changed while stalled");

	// packets are queued whole, so bytes within a packet come without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_byte |=> out_valid)
		else $error("gap inside a packet");

	// the input only backs up when the output side is holding words
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	// the config port never refuses a write
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind telemetry_tlv_group_packer tlvp_checker u_chk (.*);

`default_nettype wire
